/* sv/wrpf_pkg.sv */
// Shared constants, types and codes for the white-run far-pair block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package wrpf_pkg;

   // Sizing
   localparam int POINTS      = 8;
   localparam int MAX_COLS    = 2048;
   localparam int MAX_ROWS    = 2048;
   localparam int QUEUE_DEPTH = 2;

   localparam int IDX_W    = $clog2(POINTS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int PIX_W    = 8;
   localparam int SPAN_W   = ((COL_W > ROW_W) ? 2 * COL_W : 2 * ROW_W) + 1;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'hFF;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [COL_W-1:0] col_type;
   typedef logic [ROW_W-1:0] row_type;

   typedef struct packed {
      col_type col;
      row_type row;
   } point_type;

   // Work handed from the front end to the table/search back end
   typedef struct packed {
      logic    ins;      // store a closed run
      logic    search;   // frame end: run the pair search after any insert
      col_type col;      // run midpoint
      row_type row;
      col_type width;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_EMIT
   } back_state_type;

endpackage

/* sv/wrpf_if.sv */
// Handshake channels of the white-run far-pair block: pixel beats in, pair beats out.
// Depends on wrpf_pkg for field widths.
`timescale 1ns / 1ps

interface wrpf_req_if;
   import wrpf_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_blue;
   logic [PIX_W-1:0] pixel_green;
   logic [PIX_W-1:0] pixel_red;
   logic             row_last;
   logic             frame_last;

   modport source (output valid, pixel_blue, pixel_green, pixel_red, row_last, frame_last,
                   input  ready);
   modport sink   (input  valid, pixel_blue, pixel_green, pixel_red, row_last, frame_last,
                   output ready);
endinterface

interface wrpf_rsp_if;
   import wrpf_pkg::*;

   logic              valid;
   logic              ready;
   idx_type           first_index;
   idx_type           second_index;
   col_type           first_x;
   row_type           first_y;
   col_type           second_x;
   row_type           second_y;
   logic [SPAN_W-1:0] span_squared;

   modport source (output valid, first_index, second_index, first_x, first_y,
                   second_x, second_y, span_squared,
                   input  ready);
   modport sink   (input  valid, first_index, second_index, first_x, first_y,
                   second_x, second_y, span_squared,
                   output ready);
endinterface

/* sv/white_run_top_points_far_pair_core.sv */
// Top level of the white-run far-pair block: front end, command queue, back end.
// Depends on wrpf_pkg, wrpf_if, wrpf_front, wrpf_queue, wrpf_back.
//
//   Channel    Direction  Beat
//   req_chan   in         one RGB pixel with row and frame end marks
//   rsp_chan   out        farthest pair of stored run midpoints, one per frame
//
// Pixels are taken one per cycle while the command queue has room; a closed run
// becomes a sorted insert in the back end. A frame end starts the pair search,
// which rotates the ring past each anchor, then drains the pipeline and loads the
// result; while it runs the two-entry queue fills and req_chan.ready drops. A
// pending result holds the back end in its emit state, where it takes no commands.
// Synchronous reset clears the counters, the run state and the table at once.
`timescale 1ns / 1ps

module white_run_top_points_far_pair_core (
   input  logic        clock,
   input  logic        reset,
   wrpf_req_if.sink    req_chan,
   wrpf_rsp_if.source  rsp_chan
);
   import wrpf_pkg::*;

   logic    front_valid;
   cmd_type front_data;
   logic    front_ready;
   logic    back_valid;
   cmd_type back_data;
   logic    back_ready;

   wrpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd_data  (front_data),
      .cmd_ready (front_ready)
   );

   wrpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_data),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_data   (back_data),
      .pop_ready  (back_ready)
   );

   wrpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_data  (back_data),
      .cmd_ready (back_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* sv/wrpf_front.sv */
// Front end: column/row tracking and white-run detection on the pixel stream.
// Emits insert and frame-end commands toward the queue. Depends on wrpf_pkg, wrpf_if.
`timescale 1ns / 1ps

module wrpf_front (
   input  logic              clock,
   input  logic              reset,
   wrpf_req_if.sink          req_chan,
   output logic              cmd_valid,
   output wrpf_pkg::cmd_type cmd_data,
   input  logic              cmd_ready
);
   import wrpf_pkg::*;

   logic    run_open_ff, run_open_in;
   col_type start_ff, start_in;
   col_type col_ff, col_in;
   row_type row_ff, row_in;

   logic             accept;
   logic             white;
   logic             row_end;
   logic             close_run;
   logic [COL_W:0]   mid_sum;

   assign req_chan.ready = cmd_ready;
   assign accept         = req_chan.valid && cmd_ready;

   assign white = (req_chan.pixel_blue == WHITE_LEVEL) &&
                  (req_chan.pixel_green == WHITE_LEVEL) &&
                  (req_chan.pixel_red == WHITE_LEVEL);
   assign row_end   = req_chan.row_last || req_chan.frame_last;
   assign close_run = !white && run_open_ff;

   // Midpoint rounds down; width is end minus start
   assign mid_sum = {1'b0, start_ff} + {1'b0, col_ff};

   always_comb begin
      cmd_data.ins    = close_run;
      cmd_data.search = req_chan.frame_last;
      cmd_data.col    = mid_sum[COL_W:1];
      cmd_data.row    = row_ff;
      cmd_data.width  = col_ff - start_ff;
      cmd_valid       = accept && (close_run || req_chan.frame_last);
   end

   // Run and position tracking for the next beat
   always_comb begin
      run_open_in = run_open_ff;
      start_in    = start_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept) begin
         if (white) begin
            run_open_in = 1'b1;
            if (!run_open_ff) begin
               start_in = col_ff;
            end
         end else begin
            run_open_in = 1'b0;
         end
         if (row_end) begin
            run_open_in = 1'b0;   // run still open at row end is dropped
            col_in      = '0;
            if (req_chan.frame_last) begin
               row_in = '0;
            end else if (row_ff < ROW_W'(MAX_ROWS - 1)) begin
               row_in = row_ff + 1'b1;
            end
         end else if (col_ff < COL_W'(MAX_COLS - 1)) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         start_ff    <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         run_open_ff <= run_open_in;
         start_ff    <= start_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

endmodule

/* sv/wrpf_queue.sv */
// Short command queue between front end and back end so each side stalls on its own.
// Depends on wrpf_pkg.
`timescale 1ns / 1ps

module wrpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  wrpf_pkg::cmd_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output wrpf_pkg::cmd_type pop_data,
   input  logic              pop_ready
);
   import wrpf_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]    count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QCOUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill tracking with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/wrpf_back.sv */
// Back end: sorted table of widest runs, pair search at frame end, result register.
// The search rotates a copy of the table past a held anchor entry. Depends on wrpf_pkg, wrpf_if.
`timescale 1ns / 1ps

module wrpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  wrpf_pkg::cmd_type cmd_data,
   output logic              cmd_ready,
   wrpf_rsp_if.source        rsp_chan
);
   import wrpf_pkg::*;

   // Table of widest runs, kept in descending width order
   col_type tbl_col_ff   [POINTS];
   row_type tbl_row_ff   [POINTS];
   col_type tbl_width_ff [POINTS];
   col_type tbl_col_in   [POINTS];
   row_type tbl_row_in   [POINTS];
   col_type tbl_width_in [POINTS];
   logic [POINTS-1:0] narrower;

   // Search ring and sequencing
   back_state_type state_ff, state_in;
   col_type   ring_col_ff [POINTS];
   row_type   ring_row_ff [POINTS];
   point_type anchor_ff;
   idx_type   i_ff, i_in;
   idx_type   k_ff, k_in;
   logic      pop;
   logic      start_scan;
   logic      scanning;
   logic      last_pair;
   logic      load_out;
   logic      out_free;

   // Pipeline: differences, then squares, then compare
   logic      pair_v;
   logic      s1_v_ff, s2_v_ff;
   idx_type   s1_i_ff, s1_j_ff, s2_i_ff, s2_j_ff;
   point_type s1_a_ff, s1_b_ff, s2_a_ff, s2_b_ff;
   col_type   s1_dx_ff;
   row_type   s1_dy_ff;
   col_type   dx;
   row_type   dy;
   logic [2*COL_W-1:0] s2_sqx_ff;
   logic [2*ROW_W-1:0] s2_sqy_ff;
   logic [SPAN_W-1:0]  span_sum;
   logic               better;

   // Best pair so far
   logic [SPAN_W-1:0] best_d_ff;
   idx_type           best_i_ff, best_j_ff;
   point_type         best_a_ff, best_b_ff;

   // Result register
   logic              out_v_ff, out_v_in;
   idx_type           out_i_ff, out_j_ff;
   point_type         out_a_ff, out_b_ff;
   logic [SPAN_W-1:0] out_d_ff;

   assign pop = cmd_valid && cmd_ready;

   // Sorted insert: new run takes the first narrower slot, the rest move down one
   always_comb begin
      for (int n = 0; n < POINTS; n++) begin
         narrower[n] = (tbl_width_ff[n] < cmd_data.width);
      end
      for (int n = 0; n < POINTS; n++) begin
         tbl_col_in[n]   = tbl_col_ff[n];
         tbl_row_in[n]   = tbl_row_ff[n];
         tbl_width_in[n] = tbl_width_ff[n];
      end
      if (pop && cmd_data.ins) begin
         if (narrower[0]) begin
            tbl_col_in[0]   = cmd_data.col;
            tbl_row_in[0]   = cmd_data.row;
            tbl_width_in[0] = cmd_data.width;
         end
         for (int n = 1; n < POINTS; n++) begin
            if (narrower[n - 1]) begin
               tbl_col_in[n]   = tbl_col_ff[n - 1];
               tbl_row_in[n]   = tbl_row_ff[n - 1];
               tbl_width_in[n] = tbl_width_ff[n - 1];
            end else if (narrower[n]) begin
               tbl_col_in[n]   = cmd_data.col;
               tbl_row_in[n]   = cmd_data.row;
               tbl_width_in[n] = cmd_data.width;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < POINTS; n++) begin
            tbl_col_ff[n]   <= '0;
            tbl_row_ff[n]   <= '0;
            tbl_width_ff[n] <= '0;
         end
      end else begin
         for (int n = 0; n < POINTS; n++) begin
            tbl_col_ff[n]   <= tbl_col_in[n];
            tbl_row_ff[n]   <= tbl_row_in[n];
            tbl_width_ff[n] <= tbl_width_in[n];
         end
      end
   end

   // Sequencer: next state and controls
   assign out_free  = !out_v_ff || rsp_chan.ready;
   assign last_pair = (i_ff == IDX_W'(POINTS - 2)) && (k_ff == IDX_W'(POINTS - 1));
   assign scanning  = (state_ff == BK_SCAN);

   always_comb begin
      state_in   = state_ff;
      cmd_ready  = 1'b0;
      start_scan = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid && cmd_data.search) begin
               start_scan = 1'b1;
               state_in   = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (last_pair) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Anchor index i outer, ring head index k sweeps all slots each round
   always_comb begin
      i_in = i_ff;
      k_in = k_ff;
      if (start_scan) begin
         i_in = '0;
         k_in = '0;
      end else if (scanning) begin
         if (k_ff == IDX_W'(POINTS - 1)) begin
            k_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         k_ff <= '0;
      end else begin
         i_ff <= i_in;
         k_ff <= k_in;
      end
   end

   // Ring copy of the table: loaded at frame end, rotated once per scan cycle
   always_ff @(posedge clock) begin
      if (start_scan) begin
         for (int n = 0; n < POINTS; n++) begin
            ring_col_ff[n] <= tbl_col_in[n];
            ring_row_ff[n] <= tbl_row_in[n];
         end
      end else if (scanning) begin
         for (int n = 0; n < POINTS - 1; n++) begin
            ring_col_ff[n] <= ring_col_ff[n + 1];
            ring_row_ff[n] <= ring_row_ff[n + 1];
         end
         ring_col_ff[POINTS - 1] <= ring_col_ff[0];
         ring_row_ff[POINTS - 1] <= ring_row_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (scanning && (k_ff == i_ff)) begin
         anchor_ff.col <= ring_col_ff[0];
         anchor_ff.row <= ring_row_ff[0];
      end
   end

   // Stage 1: absolute differences between anchor and ring head
   assign pair_v = scanning && (k_ff > i_ff);
   assign dx = (anchor_ff.col > ring_col_ff[0]) ? anchor_ff.col - ring_col_ff[0]
                                                : ring_col_ff[0] - anchor_ff.col;
   assign dy = (anchor_ff.row > ring_row_ff[0]) ? anchor_ff.row - ring_row_ff[0]
                                                : ring_row_ff[0] - anchor_ff.row;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= pair_v;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_i_ff     <= i_ff;
      s1_j_ff     <= k_ff;
      s1_a_ff     <= anchor_ff;
      s1_b_ff.col <= ring_col_ff[0];
      s1_b_ff.row <= ring_row_ff[0];
      s1_dx_ff    <= dx;
      s1_dy_ff    <= dy;
      // Stage 2: squares
      s2_i_ff     <= s1_i_ff;
      s2_j_ff     <= s1_j_ff;
      s2_a_ff     <= s1_a_ff;
      s2_b_ff     <= s1_b_ff;
      s2_sqx_ff   <= (2 * COL_W)'(s1_dx_ff) * (2 * COL_W)'(s1_dx_ff);
      s2_sqy_ff   <= (2 * ROW_W)'(s1_dy_ff) * (2 * ROW_W)'(s1_dy_ff);
   end

   // Stage 3: sum and strict compare, so ties keep the earlier pair
   assign span_sum = SPAN_W'(s2_sqx_ff) + SPAN_W'(s2_sqy_ff);
   assign better   = s2_v_ff && (span_sum > best_d_ff);

   always_ff @(posedge clock) begin
      if (start_scan) begin
         best_d_ff     <= '0;
         best_i_ff     <= '0;
         best_j_ff     <= '0;
         best_a_ff.col <= tbl_col_in[0];
         best_a_ff.row <= tbl_row_in[0];
         best_b_ff.col <= tbl_col_in[0];
         best_b_ff.row <= tbl_row_in[0];
      end else if (better) begin
         best_d_ff <= span_sum;
         best_i_ff <= s2_i_ff;
         best_j_ff <= s2_j_ff;
         best_a_ff <= s2_a_ff;
         best_b_ff <= s2_b_ff;
      end
   end

   // Result register holds a beat until taken
   always_comb begin
      out_v_in = out_v_ff;
      if (load_out) begin
         out_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_i_ff <= best_i_ff;
         out_j_ff <= best_j_ff;
         out_a_ff <= best_a_ff;
         out_b_ff <= best_b_ff;
         out_d_ff <= best_d_ff;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.first_index  = out_i_ff;
   assign rsp_chan.second_index = out_j_ff;
   assign rsp_chan.first_x      = out_a_ff.col;
   assign rsp_chan.first_y      = out_a_ff.row;
   assign rsp_chan.second_x     = out_b_ff.col;
   assign rsp_chan.second_y     = out_b_ff.row;
   assign rsp_chan.span_squared = out_d_ff;

endmodule

/* verif/white_run_top_points_far_pair_core_tb.sv */
// Testbench for white_run_top_points_far_pair_core: drives pixel beats, predicts every pair beat.
// Depends on wrpf_pkg, wrpf_if and the core RTL; reads no files.
`timescale 1ns / 1ps

module white_run_top_points_far_pair_core_tb;
   import wrpf_pkg::*;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int DRAIN_CYCLES     = 200;
   localparam int RANDOM_PIXELS    = 1600;
   localparam int RANDOM_FRAMES    = 48;
   localparam int PRINT_LIMIT      = 40;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             row_last;
      logic             frame_last;
   } pixel_beat_type;

   typedef struct packed {
      idx_type           first_index;
      idx_type           second_index;
      col_type           first_x;
      row_type           first_y;
      col_type           second_x;
      row_type           second_y;
      logic [SPAN_W-1:0] span;
   } far_pair_type;

   logic clock;
   logic reset;

   wrpf_req_if req_chan ();
   wrpf_rsp_if rsp_chan ();

   white_run_top_points_far_pair_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: run tracker, counters and the sorted table of widest runs
   logic    run_open_m  = 1'b0;
   col_type run_start_m = '0;
   col_type column_m    = '0;
   row_type row_m       = '0;
   col_type table_col [POINTS]   = '{default: '0};
   row_type table_row [POINTS]   = '{default: '0};
   col_type table_width [POINTS] = '{default: '0};

   far_pair_type   far_pair_expected [$];
   pixel_beat_type row_beats [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int pixels_sent;
   int pixel_idle_pct;
   int rsp_stall_pct;

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // Sorted insert: first slot with a smaller width, the rest move down one
   function automatic void store_run(input col_type mid, input row_type row,
                                     input col_type width);
      int slot;
      int k;
      slot = POINTS;
      if (width == '0) return;
      for (k = POINTS - 1; k >= 0; k--) begin
         if (table_width[k] < width) slot = k;
      end
      if (slot >= POINTS) return;
      for (k = POINTS - 1; k > slot; k--) begin
         table_col[k]   = table_col[k-1];
         table_row[k]   = table_row[k-1];
         table_width[k] = table_width[k-1];
      end
      table_col[slot]   = mid;
      table_row[slot]   = row;
      table_width[slot] = width;
   endfunction

   // Farthest pair over all slots; strict compare keeps the first of equal spans
   function automatic far_pair_type find_far_pair();
      far_pair_type      pair;
      logic [SPAN_W-1:0] best;
      logic [SPAN_W-1:0] span_d;
      col_type           dx;
      row_type           dy;
      int                i;
      int                j;
      int                a;
      int                b;
      best = '0;
      a = 0;
      b = 0;
      for (i = 0; i < POINTS; i++) begin
         for (j = i + 1; j < POINTS; j++) begin
            dx = (table_col[i] > table_col[j]) ? table_col[i] - table_col[j]
                                               : table_col[j] - table_col[i];
            dy = (table_row[i] > table_row[j]) ? table_row[i] - table_row[j]
                                               : table_row[j] - table_row[i];
            span_d = SPAN_W'(dx) * SPAN_W'(dx) + SPAN_W'(dy) * SPAN_W'(dy);
            if (span_d > best) begin
               best = span_d;
               a = i;
               b = j;
            end
         end
      end
      pair.first_index  = idx_type'(a);
      pair.second_index = idx_type'(b);
      pair.first_x      = table_col[a];
      pair.first_y      = table_row[a];
      pair.second_x     = table_col[b];
      pair.second_y     = table_row[b];
      pair.span         = best;
      return pair;
   endfunction

   // One accepted pixel through the run tracker and counters
   function automatic void absorb_pixel(input pixel_beat_type beat);
      logic         white;
      logic         row_end;
      col_type      col;
      logic [COL_W:0] mid_sum;
      white = beat.blue == WHITE_LEVEL && beat.green == WHITE_LEVEL &&
              beat.red == WHITE_LEVEL;
      row_end = beat.row_last | beat.frame_last;
      col = column_m;
      if (white) begin
         if (!run_open_m) begin
            run_open_m  = 1'b1;
            run_start_m = col;
         end
      end else if (run_open_m) begin
         run_open_m = 1'b0;
         mid_sum = {1'b0, run_start_m} + {1'b0, col};
         store_run(mid_sum[COL_W:1], row_m, col - run_start_m);
      end
      if (row_end) begin
         run_open_m = 1'b0;
         column_m   = '0;
         if (beat.frame_last) row_m = '0;
         else if (row_m < MAX_ROWS - 1) row_m = row_m + 1'b1;
      end else if (column_m < MAX_COLS - 1) begin
         column_m = column_m + 1'b1;
      end
      if (beat.frame_last) far_pair_expected = {far_pair_expected, find_far_pair()};
   endfunction

   // Monitor both channels, drive the receiver's ready, watch the clock budget
   always @(posedge clock) begin
      far_pair_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         absorb_pixel({req_chan.pixel_blue, req_chan.pixel_green, req_chan.pixel_red,
                       req_chan.row_last, req_chan.frame_last});
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (far_pair_expected.size() == 0) begin
            report_mismatch("pair beat with no frame end pending");
         end else begin
            want = far_pair_expected.pop_front();
            check_field("first_index", 32'(rsp_chan.first_index), 32'(want.first_index));
            check_field("second_index", 32'(rsp_chan.second_index), 32'(want.second_index));
            check_field("first_x", 32'(rsp_chan.first_x), 32'(want.first_x));
            check_field("first_y", 32'(rsp_chan.first_y), 32'(want.first_y));
            check_field("second_x", 32'(rsp_chan.second_x), 32'(want.second_x));
            check_field("second_y", 32'(rsp_chan.second_y), 32'(want.second_y));
            check_field("span_squared", 32'(rsp_chan.span_squared), 32'(want.span));
         end
      end
      rsp_chan.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // One pixel beat, after a random idle gap; returns at the accepting edge
   task automatic send_pixel(input pixel_beat_type beat);
      while (pixel_idle_pct != 0 && $urandom_range(99) < pixel_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pixel_blue  <= beat.blue;
      req_chan.pixel_green <= beat.green;
      req_chan.pixel_red   <= beat.red;
      req_chan.row_last    <= beat.row_last;
      req_chan.frame_last  <= beat.frame_last;
      do @(posedge clock); while (!req_chan.ready);
      pixels_sent++;
   endtask

   // Row builders: collect pixels, then mark the last one and send the row
   function automatic void push_pixel(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r);
      pixel_beat_type beat;
      beat.blue       = b;
      beat.green      = g;
      beat.red        = r;
      beat.row_last   = 1'b0;
      beat.frame_last = 1'b0;
      row_beats = {row_beats, beat};
   endfunction

   function automatic void push_white(input int count);
      repeat (count) push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
   endfunction

   // White with one bit cleared in one channel
   function automatic void push_near_white();
      logic [7:0] off;
      off = WHITE_LEVEL ^ (8'd1 << $urandom_range(7));
      case ($urandom_range(2))
         0: push_pixel(off, WHITE_LEVEL, WHITE_LEVEL);
         1: push_pixel(WHITE_LEVEL, off, WHITE_LEVEL);
         default: push_pixel(WHITE_LEVEL, WHITE_LEVEL, off);
      endcase
   endfunction

   function automatic void push_dark(input int count);
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      repeat (count) begin
         if ($urandom_range(3) == 0) begin
            push_near_white();
         end else begin
            b = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            r = 8'($urandom_range(255));
            if (b == WHITE_LEVEL && g == WHITE_LEVEL && r == WHITE_LEVEL)
               b[3'($urandom_range(7))] = 1'b0;
            push_pixel(b, g, r);
         end
      end
   endfunction

   task automatic flush_row(input logic row_mark, input logic frame_end);
      pixel_beat_type beat;
      if (row_beats.size() == 0) push_dark(1);
      beat = row_beats[row_beats.size() - 1];
      beat.row_last   = row_mark;
      beat.frame_last = frame_end;
      row_beats[row_beats.size() - 1] = beat;
      while (row_beats.size() != 0) send_pixel(row_beats.pop_front());
   endtask

   task automatic send_row(input int lead, input int run_len, input int trail,
                           input logic frame_end);
      push_dark(lead);
      push_white(run_len);
      push_dark(trail);
      flush_row(1'b1, frame_end);
   endtask

   // Frame with no runs: every slot empty, no positive span
   task automatic test_empty_table();
      push_pixel(8'h00, 8'h00, 8'h00);
      flush_row(1'b1, 1'b1);
   endtask

   // Byte extremes; near-white in each channel closes a run. With most slots
   // still empty the far pair ties across empty slots and the first is kept.
   task automatic test_pixel_extremes();
      push_pixel(8'h00, 8'h00, 8'h00);
      push_white(2);
      push_pixel(8'hFE, WHITE_LEVEL, WHITE_LEVEL);
      push_white(1);
      push_pixel(WHITE_LEVEL, WHITE_LEVEL, 8'h7F);
      push_white(1);
      push_pixel(WHITE_LEVEL, 8'hBF, WHITE_LEVEL);
      push_white(1);
      flush_row(1'b1, 1'b1);
   endtask

   // Dark last pixel closes its run; white last pixel drops it; frame end
   // without a row mark still ends the row
   task automatic test_row_end_cases();
      send_row(0, 2, 1, 1'b0);
      send_row(1, 2, 0, 1'b0);
      push_white(3);
      push_dark(1);
      flush_row(1'b0, 1'b1);
   endtask

   // Equal widths never displace; a wider run goes to the top of a full table
   task automatic test_equal_widths();
      repeat (10) send_row(0, 3, 1, 1'b0);
      send_row(2, 4, 1, 1'b1);
   endtask

   // Column count saturates; a run opened at the saturated column has zero width
   task automatic test_column_saturation();
      push_dark(MAX_COLS - 6);
      push_white(8);
      push_dark(1);
      push_white(1);
      push_dark(1);
      push_white(2);
      flush_row(1'b1, 1'b0);
      send_row(0, 1, 1, 1'b1);
   endtask

   // Row count saturates; runs on the last row land at the top row number
   task automatic test_row_saturation();
      repeat (MAX_ROWS) send_row(1, 0, 0, 1'b0);
      send_row(1, 6, 1, 1'b0);
      send_row(0, 7, 2, 1'b1);
   endtask

   // Mostly well-formed frames of runs whose widths grow so the table keeps
   // changing; split runs, runs open at row end and bare frame ends as noise
   task automatic test_random_frames();
      int base;
      int frame_idx;
      int width_cap;
      int rows;
      int runs;
      int run_len;
      int r;
      int k;
      base = pixels_sent;
      frame_idx = 0;
      while (pixels_sent - base < RANDOM_PIXELS || frame_idx < RANDOM_FRAMES) begin
         case ((frame_idx / 3) % 4)
            0: begin pixel_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin pixel_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin pixel_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin pixel_idle_pct = 13; rsp_stall_pct = 13; end
         endcase
         width_cap = 3 + frame_idx / 2;
         rows = $urandom_range(1, 3);
         for (r = 0; r < rows; r++) begin
            runs = $urandom_range(0, 3);
            for (k = 0; k < runs; k++) begin
               push_dark($urandom_range(0, 3));
               run_len = $urandom_range(1, width_cap);
               if ($urandom_range(7) == 0 && run_len > 2) begin
                  push_white(run_len / 2);
                  push_near_white();
                  push_white(run_len / 2);
               end else begin
                  push_white(run_len);
               end
            end
            if ($urandom_range(3) != 0) push_dark($urandom_range(1, 2));
            if (r == rows - 1) flush_row(1'($urandom_range(1)), 1'b1);
            else flush_row(1'b1, 1'b0);
         end
         frame_idx++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      pixels_sent    = 0;
      pixel_idle_pct = 0;
      rsp_stall_pct  = 0;
      req_chan.valid       = 1'b0;
      req_chan.pixel_blue  = '0;
      req_chan.pixel_green = '0;
      req_chan.pixel_red   = '0;
      req_chan.row_last    = 1'b0;
      req_chan.frame_last  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_pixel_extremes();
      test_row_end_cases();
      test_equal_widths();
      test_column_saturation();
      test_row_saturation();
      test_random_frames();

      // Drain outstanding pair beats, then watch for strays
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (far_pair_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
